// ===== rtl/rplm_pkg.sv =====
// ----------------------------------------------------------------------------
// rplm_pkg
// shared types, codes and defaults of the resource pool lock manager
// ----------------------------------------------------------------------------
package rplm_pkg;

  localparam int ELEMENTS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int CLIENT_BITS_DEF = 16;

  localparam int STATUS_W    = 3;
  localparam int ELEM_IDX_W  = 4;
  localparam int CFG_COUNT_W = 5;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [CFG_COUNT_W-1:0]  COUNT_RESET       = CFG_COUNT_W'(16);
  localparam logic [APB_ADDR_W-3:0]   REG_ELEMENT_COUNT = '0;

  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_ENQUEUED  = 3'd1,
    ST_BUSY      = 3'd2,
    ST_QFULL     = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_LEFT      = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_FREE,
    S_OWN,
    S_QSCAN,
    S_SHRD,
    S_SHWR,
    S_HEAD,
    S_GRANT,
    S_EMIT1,
    S_EMIT2
  } state_t;

  typedef struct packed {
    status_t                status;
    logic [ELEM_IDX_W-1:0]  elem;
    logic                   last;
  } res_meta_t;

endpackage

// ===== rtl/rplm_out_reg.sv =====
// ----------------------------------------------------------------------------
// rplm_out_reg
// result output register, frees the engine while a transfer is pending
// ----------------------------------------------------------------------------
module rplm_out_reg import rplm_pkg::*; #(
  parameter int CLIENT_BITS = CLIENT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  res_meta_t              meta,
  input  logic [CLIENT_BITS-1:0] client,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    status,
  output logic [CLIENT_BITS-1:0] target_client,
  output logic [ELEM_IDX_W-1:0]  element_index,
  output logic                   last
);

  res_meta_t meta_q;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meta_q        <= meta;
      target_client <= client;
    end
  end

  assign status        = meta_q.status;
  assign element_index = meta_q.elem;
  assign last          = meta_q.last;

endmodule

// ===== rtl/resource_pool_lock_manager.sv =====
// ----------------------------------------------------------------------------
// resource_pool_lock_manager
// counting semaphore over a pool of elements with a fifo wait queue
// lock: pointer reduced modulo count, free search over up to count elements, then output
// unlock: owner scan over up to count elements, then output; a grant to a waiter adds
//   the pointer reduction, the free search, a read of the queue head and the grant; a
//   dequeue adds a scan of the waiting entries and a read and a write per shifted entry
// one request at a time; a new request is taken while a result waits in the output register
// sync reset: every element free, queue empty, pointer zero, element_count 16, no clearing pass
// ----------------------------------------------------------------------------
module resource_pool_lock_manager import rplm_pkg::*; #(
  parameter int ELEMENTS    = ELEMENTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int CLIENT_BITS = CLIENT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   opcode,
  input  logic [CLIENT_BITS-1:0] client_id,
  input  logic                   queue_ok,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    status,
  output logic [CLIENT_BITS-1:0] target_client,
  output logic [ELEM_IDX_W-1:0]  element_index,
  output logic                   last
);

  localparam int EW  = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int CW  = $clog2(ELEMENTS + 1);
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int QSW = QCW + 1;

  state_t state, state_next;

  logic [CFG_COUNT_W-1:0] element_count;
  logic [CW-1:0]          n;
  logic                   cfg_we;

  logic                   req_op;
  logic [CLIENT_BITS-1:0] req_client;
  logic                   req_wait;

  logic [EW-1:0]          rr_pointer;
  logic [EW-1:0]          rr_work;
  logic [EW-1:0]          pos;
  logic [CW-1:0]          cnt;
  logic [EW-1:0]          free_elem;
  logic [ELEMENTS-1:0]    owner_valid;

  logic [CW-1:0]          own_issue;
  logic                   own_vld;
  logic [EW-1:0]          own_idx;

  logic [QW-1:0]          q_head;
  logic [QCW-1:0]         q_count;
  logic [QCW-1:0]         q_issue;
  logic [QW-1:0]          q_iaddr;
  logic                   qc_vld;
  logic [QCW-1:0]         qc_pos;
  logic [QW-1:0]          qc_addr;
  logic [QSW-1:0]         tail_sum;
  logic [QW-1:0]          q_tail;
  logic                   q_full;

  res_meta_t              res1_meta, res2_meta, res_meta;
  logic [CLIENT_BITS-1:0] res1_client, res2_client, res_client;
  logic                   two_res;
  logic                   res_load, res_free;

  logic [CLIENT_BITS-1:0] owner_mem [ELEMENTS];
  logic [CLIENT_BITS-1:0] owner_rdata;
  logic                   o_we;
  logic [EW-1:0]          o_waddr, o_raddr;
  logic [CLIENT_BITS-1:0] o_wdata;

  logic [CLIENT_BITS-1:0] queue_mem [QUEUE_DEPTH];
  logic [CLIENT_BITS-1:0] queue_rdata;
  logic                   q_we;
  logic [QW-1:0]          q_waddr, q_raddr;
  logic [CLIENT_BITS-1:0] q_wdata;

  logic                   accept;
  logic                   norm_more, free_hit, free_end;
  logic                   own_hit, own_end, q_hit, q_end, sh_more;
  logic [EW-1:0]          pos_inc, rr_inc;

  function automatic logic [QW-1:0] q_wrap_inc(input logic [QW-1:0] a);
    return (a == QW'(QUEUE_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_ELEMENT_COUNT);
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_ELEMENT_COUNT) ?
                  APB_DATA_W'(element_count) : '0;

  always_comb begin
    if (element_count == '0) begin
      n = CW'(1);
    end else if (int'(element_count) > ELEMENTS) begin
      n = CW'(ELEMENTS);
    end else begin
      n = CW'(element_count);
    end
  end

  // status flags
  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign norm_more = CW'(rr_work) >= n;
  assign free_hit  = !owner_valid[pos];
  assign free_end  = cnt == n - 1'b1;
  assign pos_inc   = (CW'(pos) + 1'b1 == n) ? '0 : pos + 1'b1;
  assign rr_inc    = (CW'(rr_work) + 1'b1 == n) ? '0 : rr_work + 1'b1;
  assign own_hit   = own_vld && owner_valid[own_idx] && (owner_rdata == req_client);
  assign own_end   = !own_vld && (own_issue >= n);
  assign q_hit     = qc_vld && (queue_rdata == req_client);
  assign q_end     = !qc_vld && (q_issue >= q_count);
  assign sh_more   = (QSW'(qc_pos) + 1'b1) < QSW'(q_count);
  assign q_full    = q_count == QCW'(QUEUE_DEPTH);
  assign tail_sum  = QSW'(q_head) + QSW'(q_count);
  assign q_tail    = (int'(tail_sum) >= QUEUE_DEPTH) ? QW'(int'(tail_sum) - QUEUE_DEPTH)
                                                     : QW'(tail_sum);
  assign o_raddr   = (own_issue < n) ? EW'(own_issue) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    o_we       = 1'b0;
    o_waddr    = free_elem;
    o_wdata    = req_client;
    q_we       = 1'b0;
    q_waddr    = q_tail;
    q_wdata    = req_client;
    q_raddr    = q_iaddr;
    res_load   = 1'b0;
    res_meta   = res1_meta;
    res_client = res1_client;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (opcode == OP_LOCK) ? S_NORM : S_OWN;
        end
      end
      S_NORM: begin
        if (!norm_more) begin
          state_next = S_FREE;
        end
      end
      S_FREE: begin
        if (free_hit) begin
          if (req_op == OP_LOCK) begin
            o_we       = 1'b1;
            o_waddr    = pos;
            state_next = S_EMIT1;
          end else begin
            state_next = S_HEAD;
          end
        end else if (free_end) begin
          q_we       = req_wait && !q_full;
          state_next = S_EMIT1;
        end
      end
      S_OWN: begin
        if (own_hit) begin
          state_next = (q_count != '0) ? S_NORM : S_EMIT1;
        end else if (own_end) begin
          state_next = S_QSCAN;
        end
      end
      S_QSCAN: begin
        if (q_hit) begin
          state_next = S_SHRD;
        end else if (q_end) begin
          state_next = S_EMIT1;
        end
      end
      S_SHRD: begin
        q_raddr = q_wrap_inc(qc_addr);
        state_next = sh_more ? S_SHWR : S_EMIT1;
      end
      S_SHWR: begin
        q_we       = 1'b1;
        q_waddr    = qc_addr;
        q_wdata    = queue_rdata;
        state_next = S_SHRD;
      end
      S_HEAD: begin
        q_raddr    = q_head;
        state_next = S_GRANT;
      end
      S_GRANT: begin
        o_we       = 1'b1;
        o_wdata    = queue_rdata;
        state_next = S_EMIT1;
      end
      S_EMIT1: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = two_res ? S_EMIT2 : S_IDLE;
        end
      end
      S_EMIT2: begin
        res_meta   = res2_meta;
        res_client = res2_client;
        if (res_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // pool and queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= COUNT_RESET;
      rr_pointer    <= '0;
      owner_valid   <= '0;
      q_head        <= '0;
      q_count       <= '0;
    end else begin
      if (cfg_we) begin
        element_count <= pwdata[CFG_COUNT_W-1:0];
      end
      case (state)
        S_FREE: begin
          if (free_hit && req_op == OP_LOCK) begin
            owner_valid[pos] <= 1'b1;
            rr_pointer       <= rr_inc;
          end else if (!free_hit && free_end && req_wait && !q_full) begin
            q_count <= q_count + 1'b1;
          end
        end
        S_OWN: begin
          if (own_hit) begin
            owner_valid[own_idx] <= 1'b0;
          end
        end
        S_SHRD: begin
          if (!sh_more) begin
            q_count <= q_count - 1'b1;
          end
        end
        S_GRANT: begin
          owner_valid[free_elem] <= 1'b1;
          rr_pointer             <= rr_inc;
          q_head                 <= q_wrap_inc(q_head);
          q_count                <= q_count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // request and scan registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          req_op     <= opcode;
          req_client <= client_id;
          req_wait   <= queue_ok;
          rr_work    <= rr_pointer;
          own_issue  <= '0;
          own_vld    <= 1'b0;
        end
      end
      S_NORM: begin
        if (norm_more) begin
          rr_work <= EW'(CW'(rr_work) - n);
        end else begin
          pos <= rr_work;
          cnt <= '0;
        end
      end
      S_FREE: begin
        if (free_hit) begin
          free_elem <= pos;
          if (req_op == OP_LOCK) begin
            res1_meta   <= '{status: ST_GRANTED, elem: ELEM_IDX_W'(pos), last: 1'b1};
            res1_client <= req_client;
            two_res     <= 1'b0;
          end
        end else if (free_end) begin
          res1_meta.status <= !req_wait ? ST_BUSY : (q_full ? ST_QFULL : ST_ENQUEUED);
          res1_meta.elem   <= '0;
          res1_meta.last   <= 1'b1;
          res1_client      <= req_client;
          two_res          <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
          pos <= pos_inc;
        end
      end
      S_OWN: begin
        if (own_hit) begin
          rr_work     <= rr_pointer;
          res1_meta   <= '{status: ST_RELEASED, elem: ELEM_IDX_W'(own_idx),
                           last: (q_count == '0)};
          res1_client <= req_client;
          two_res     <= 1'b0;
        end else if (own_end) begin
          q_issue <= '0;
          q_iaddr <= q_head;
          qc_vld  <= 1'b0;
        end else if (own_issue < n) begin
          own_idx   <= EW'(own_issue);
          own_vld   <= 1'b1;
          own_issue <= own_issue + 1'b1;
        end else begin
          own_vld <= 1'b0;
        end
      end
      S_QSCAN: begin
        if (!q_hit) begin
          if (q_end) begin
            res1_meta   <= '{status: ST_NOT_FOUND, elem: '0, last: 1'b1};
            res1_client <= req_client;
            two_res     <= 1'b0;
          end else if (q_issue < q_count) begin
            qc_pos  <= q_issue;
            qc_addr <= q_iaddr;
            qc_vld  <= 1'b1;
            q_issue <= q_issue + 1'b1;
            q_iaddr <= q_wrap_inc(q_iaddr);
          end else begin
            qc_vld <= 1'b0;
          end
        end
      end
      S_SHRD: begin
        if (!sh_more) begin
          res1_meta   <= '{status: ST_LEFT, elem: '0, last: 1'b1};
          res1_client <= req_client;
          two_res     <= 1'b0;
        end
      end
      S_SHWR: begin
        qc_pos  <= qc_pos + 1'b1;
        qc_addr <= q_wrap_inc(qc_addr);
      end
      S_GRANT: begin
        res2_meta   <= '{status: ST_GRANTED, elem: ELEM_IDX_W'(free_elem), last: 1'b1};
        res2_client <= queue_rdata;
        two_res     <= 1'b1;
      end
      default: ;
    endcase
  end

  // owner table
  always_ff @(posedge clk) begin
    if (o_we) begin
      owner_mem[o_waddr] <= o_wdata;
    end
    owner_rdata <= owner_mem[o_raddr];
  end

  // wait queue, circular
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    queue_rdata <= queue_mem[q_raddr];
  end

  rplm_out_reg #(
    .CLIENT_BITS(CLIENT_BITS)
  ) u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (res_load),
    .meta          (res_meta),
    .client        (res_client),
    .free          (res_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .target_client (target_client),
    .element_index (element_index),
    .last          (last)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCW'(QUEUE_DEPTH))
    else $error("wait queue count beyond depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request taken while busy");

  a_second_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("second result of an unlock missing");

  a_grant_has_waiter: assert property (@(posedge clk) disable iff (rst)
    (state == S_GRANT) |-> (q_count != '0))
    else $error("grant to waiter with empty queue");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: resource pool lock manager testbench
// drives lock and unlock requests under random gaps and output stalls and
// checks every result against a cycle-free model of the pool, the round-robin
// pointer and the wait queue, over a range of pool sizes set through apb
// ----------------------------------------------------------------------------
module tb_top;
  import rplm_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 200;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int POOL_SIZE       = 20;
  localparam int MAX_REPORTS     = 10;

  localparam logic [APB_ADDR_W-1:0] ADDR_ELEMENT_COUNT = {REG_ELEMENT_COUNT, 2'b00};

  localparam logic [15:0] CL_LOW  = 16'h0000;
  localparam logic [15:0] CL_HIGH = 16'hFFFF;
  localparam logic [15:0] CL_P    = 16'h1234;
  localparam logic [15:0] CL_Q    = 16'h8001;
  localparam logic [15:0] CL_R    = 16'h5555;
  localparam logic [15:0] CL_S    = 16'hAAAA;
  localparam logic [15:0] CL_T    = 16'h7F00;
  localparam logic [15:0] CL_U    = 16'h00FF;

  typedef struct packed {
    logic        op;
    logic [15:0] client;
    logic        wait_ok;
  } lock_req_t;

  typedef struct packed {
    status_t               status;
    logic [15:0]           client;
    logic [ELEM_IDX_W-1:0] elem;
    logic                  last;
  } lock_result_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  opcode    = OP_LOCK;
  logic [15:0]           client_id = '0;
  logic                  queue_ok  = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [15:0]           target_client;
  logic [ELEM_IDX_W-1:0] element_index;
  logic                  last;

  // model of the pool
  logic [15:0]            holder_id [ELEMENTS_DEF];
  bit                     holder_valid [ELEMENTS_DEF];
  int                     rr_next;
  logic [15:0]            waiters [$];
  logic [CFG_COUNT_W-1:0] pool_count_cfg;

  lock_req_t    pending_requests [$];
  lock_result_t expected_results [$];
  int           outcome_tally [8];

  lock_req_t    next_req;
  lock_result_t want;
  int           gap_left;
  int           stall_left;
  bit           in_burst;
  bit           out_burst;
  int           items_accepted;
  int           results_checked;
  int           mismatch_count;
  int           settings_used;
  int           cycle_count;
  logic [15:0]  client_pool [POOL_SIZE];

  resource_pool_lock_manager u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .client_id     (client_id),
    .queue_ok      (queue_ok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .target_client (target_client),
    .element_index (element_index),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_elements();
    if (pool_count_cfg == 0) return 1;
    if (pool_count_cfg > ELEMENTS_DEF) return ELEMENTS_DEF;
    return int'(pool_count_cfg);
  endfunction

  function automatic bit find_free_element(output int idx);
    int n;
    int j;
    n = active_elements();
    idx = 0;
    for (int i = 0; i < n; i++) begin
      j = (i + rr_next) % n;
      if (!holder_valid[j]) begin
        idx = j;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void take_element(int idx, logic [15:0] cid);
    holder_id[idx]    = cid;
    holder_valid[idx] = 1'b1;
    rr_next           = (rr_next + 1) % active_elements();
  endfunction

  function automatic void record_outcome(status_t st, logic [15:0] cid, int idx, logic fin);
    lock_result_t r;
    r.status = st;
    r.client = cid;
    r.elem   = ELEM_IDX_W'(idx);
    r.last   = fin;
    expected_results.push_back(r);
    outcome_tally[st]++;
  endfunction

  function automatic void predict_lock_outcome(logic op, logic [15:0] cid, logic cw);
    int n;
    int f;
    logic [15:0] head;
    if (op == OP_LOCK) begin
      if (find_free_element(f)) begin
        take_element(f, cid);
        record_outcome(ST_GRANTED, cid, f, 1'b1);
      end else if (!cw) begin
        record_outcome(ST_BUSY, cid, 0, 1'b1);
      end else if (waiters.size() >= QUEUE_DEPTH_DEF) begin
        record_outcome(ST_QFULL, cid, 0, 1'b1);
      end else begin
        waiters.push_back(cid);
        record_outcome(ST_ENQUEUED, cid, 0, 1'b1);
      end
      return;
    end
    n = active_elements();
    for (int e = 0; e < n; e++) begin
      if (holder_valid[e] && holder_id[e] == cid) begin
        holder_valid[e] = 1'b0;
        if (waiters.size() > 0 && find_free_element(f)) begin
          head = waiters.pop_front();
          take_element(f, head);
          record_outcome(ST_RELEASED, cid, e, 1'b0);
          record_outcome(ST_GRANTED, head, f, 1'b1);
        end else begin
          record_outcome(ST_RELEASED, cid, e, 1'b1);
        end
        return;
      end
    end
    foreach (waiters[k]) begin
      if (waiters[k] == cid) begin
        waiters.delete(k);
        record_outcome(ST_LEFT, cid, 0, 1'b1);
        return;
      end
    end
    record_outcome(ST_NOT_FOUND, cid, 0, 1'b1);
  endfunction

  function automatic void add_req(logic op, logic [15:0] cid, logic cw);
    lock_req_t r;
    r.op      = op;
    r.client  = cid;
    r.wait_ok = cw;
    pending_requests.push_back(r);
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic settle_and_set_count(input logic [CFG_COUNT_W-1:0] v);
    wait_idle();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ELEMENT_COUNT;
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pool_count_cfg = v;
    settings_used++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      in_burst <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_lock_outcome(opcode, client_id, queue_ok);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_requests.size() > 0) begin
          next_req  = pending_requests.pop_front();
          opcode    <= next_req.op;
          client_id <= next_req.client;
          queue_ok  <= next_req.wait_ok;
          in_valid  <= 1'b1;
          gap_left  <= in_burst ? 0 : $urandom_range(0, 10);
          if ($urandom_range(0, 63) == 0) in_burst <= !in_burst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      out_burst  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: status %0d client %h elem %0d last %0b",
                     status, target_client, element_index, last);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status || target_client !== want.client ||
              element_index !== want.elem || last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"result mismatch: exp status %0d client %h elem %0d last %0b, ",
                        "got status %0d client %h elem %0d last %0b"},
                       want.status, want.client, want.elem, want.last,
                       status, target_client, element_index, last);
          end
        end
        stall_left <= out_burst ? 0 : $urandom_range(0, 10);
        out_ready  <= out_burst;
        if ($urandom_range(0, 63) == 0) out_burst <= !out_burst;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= (stall_left == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int lock_pct;
    lock_req_t r;
    logic [CFG_COUNT_W-1:0] count_plan [6];
    count_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd3};
    pool_count_cfg = COUNT_RESET;
    rr_next = 0;
    foreach (holder_valid[i]) holder_valid[i] = 1'b0;
    client_pool[0] = CL_LOW;
    client_pool[1] = CL_HIGH;
    for (int i = 2; i < POOL_SIZE; i++) client_pool[i] = 16'($urandom);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // two elements: grant, busy, wait, leave queue, miss, release with hand-over
    settle_and_set_count(5'd2);
    add_req(OP_LOCK, CL_LOW, 1'b0);
    add_req(OP_LOCK, CL_HIGH, 1'b0);
    add_req(OP_LOCK, CL_P, 1'b0);
    add_req(OP_LOCK, CL_P, 1'b1);
    add_req(OP_LOCK, CL_Q, 1'b1);
    add_req(OP_UNLOCK, CL_Q, 1'b0);
    add_req(OP_UNLOCK, CL_R, 1'b1);
    add_req(OP_UNLOCK, CL_LOW, 1'b0);
    add_req(OP_LOCK, CL_Q, 1'b1);
    // pool grows with a waiter present: lock still granted at once
    settle_and_set_count(5'd3);
    add_req(OP_LOCK, CL_R, 1'b0);
    add_req(OP_UNLOCK, CL_HIGH, 1'b1);
    // shrink: holds beyond the count are invisible to unlock
    settle_and_set_count(5'd1);
    add_req(OP_UNLOCK, CL_Q, 1'b0);
    add_req(OP_UNLOCK, CL_R, 1'b0);
    add_req(OP_LOCK, CL_S, 1'b1);
    // zero count acts as one
    settle_and_set_count(5'd0);
    add_req(OP_UNLOCK, CL_P, 1'b0);
    add_req(OP_LOCK, CL_LOW, 1'b0);
    // count above the pool acts as the full pool, old holds visible again
    settle_and_set_count(5'd31);
    add_req(OP_LOCK, CL_HIGH, 1'b0);
    add_req(OP_UNLOCK, CL_Q, 1'b0);
    add_req(OP_LOCK, CL_LOW, 1'b0);
    // pointer beyond the new count wraps
    settle_and_set_count(5'd3);
    add_req(OP_LOCK, CL_T, 1'b1);
    add_req(OP_LOCK, CL_U, 1'b1);
    add_req(OP_LOCK, CL_LOW, 1'b1);
    add_req(OP_UNLOCK, CL_T, 1'b0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_and_set_count(p < 6 ? count_plan[p] : CFG_COUNT_W'($urandom_range(0, 31)));
      lock_pct = $urandom_range(45, 75);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r.op      = ($urandom_range(0, 99) < lock_pct) ? OP_LOCK : OP_UNLOCK;
        r.client  = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                : client_pool[$urandom_range(0, POOL_SIZE - 1)];
        r.wait_ok = ($urandom_range(0, 4) != 0);
        pending_requests.push_back(r);
      end
    end

    wait_idle();
    mismatch_count += expected_results.size();
    $display("ran %0d requests under %0d pool size settings, %0d results checked",
             items_accepted, settings_used, results_checked);
    $display({"granted %0d enqueued %0d busy %0d queue_full %0d ",
              "released %0d left %0d not_found %0d"},
             outcome_tally[ST_GRANTED], outcome_tally[ST_ENQUEUED], outcome_tally[ST_BUSY],
             outcome_tally[ST_QFULL], outcome_tally[ST_RELEASED], outcome_tally[ST_LEFT],
             outcome_tally[ST_NOT_FOUND]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
